// File: rtl/sm3_pkg.sv
`default_nettype none
package sm3_pkg;

	typedef struct packed {
		logic       kind;
		logic [7:0] message_byte;
	} sm3_in_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic [2:0]  word_index;
		logic        last;
	} sm3_out_t;

	localparam logic KIND_BYTE   = 1'b0;
	localparam logic KIND_FINISH = 1'b1;

	localparam logic [255:0] SM3_IV = {
		32'h7380166F, 32'h4914B2B9, 32'h172442D7, 32'hDA8A0600,
		32'hA96F30BC, 32'h163138AA, 32'hE38DEE4D, 32'hB0FB0E4E
	};
	localparam logic [31:0] T_LOW  = 32'h79CC4519;
	localparam logic [31:0] T_HIGH = 32'h7A879D8A;

	function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] n);
		logic [63:0] d;
		d = {x, x} << n;
		return d[63:32];
	endfunction

	function automatic logic [31:0] perm0(input logic [31:0] x);
		return x ^ rotl(x, 5'd9) ^ rotl(x, 5'd17);
	endfunction

	function automatic logic [31:0] perm1(input logic [31:0] x);
		return x ^ rotl(x, 5'd15) ^ rotl(x, 5'd23);
	endfunction

endpackage
`default_nettype wire

// File: rtl/sm3_fifo.sv
`default_nettype none
module sm3_fifo (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              push,
	input  sm3_pkg::sm3_in_t din,
	output logic             full,
	input  wire              pop,
	output logic             empty,
	output sm3_pkg::sm3_in_t dout
);
	import sm3_pkg::*;

	sm3_in_t    mem_q [4];
	logic [1:0] wp_q, rp_q;
	logic [2:0] cnt_q;

	assign full  = (cnt_q == 3'd4);
	assign empty = (cnt_q == 3'd0);
	assign dout  = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push && !full) mem_q[wp_q] <= din;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push && !full) wp_q <= wp_q + 2'd1;
			if (pop && !empty) rp_q <= rp_q + 2'd1;
			cnt_q <= cnt_q + {2'b0, push && !full} - {2'b0, pop && !empty};
		end
	end
endmodule
`default_nettype wire

// File: rtl/sm3_core.sv
`default_nettype none
module sm3_core (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               in_valid,
	input  sm3_pkg::sm3_in_t  in_item,
	output logic              in_take,
	output logic              empty,
	input  wire               pop,
	output sm3_pkg::sm3_out_t result
);
	import sm3_pkg::*;

	typedef enum logic [2:0] {S_IDLE, S_PAD, S_COMP, S_EMIT} state_t;

	state_t       state_q;
	logic [255:0] cv_q;
	logic [31:0]  w_q [16];
	logic [31:0]  a_q, b_q, c_q, d_q, e_q, f_q, g_q, h_q;
	logic [63:0]  bits_q;
	logic [63:0]  len_q;
	logic [5:0]   rnd_q;
	logic         fin_q;
	logic         second_q;
	logic [2:0]   oidx_q;

	logic [31:0]  wj, wj4, wn, ff, gg, tj, a12, ss1, ss2, tt1, tt2;
	logic [3:0]   kidx;
	logic [5:0]   pos;

	assign in_take = (state_q == S_IDLE) && in_valid;
	assign empty   = (state_q != S_EMIT);
	assign result.digest_word = cv_q[255 - 32*oidx_q -: 32];
	assign result.word_index  = oidx_q;
	assign result.last        = (oidx_q == 3'd7);

	// w_q is a 16-word window sliding by one word per round.
	assign wj  = w_q[0];
	assign wj4 = w_q[4];
	assign wn  = perm1(w_q[0] ^ w_q[7] ^ rotl(w_q[13], 5'd15)) ^ rotl(w_q[3], 5'd7) ^ w_q[10];
	assign tj  = rotl((rnd_q < 6'd16) ? T_LOW : T_HIGH, rnd_q[4:0]);
	assign ff  = (rnd_q < 6'd16) ? (a_q ^ b_q ^ c_q)
		: ((a_q & b_q) | (a_q & c_q) | (b_q & c_q));
	assign gg  = (rnd_q < 6'd16) ? (e_q ^ f_q ^ g_q) : ((e_q & f_q) | (~e_q & g_q));
	assign a12 = rotl(a_q, 5'd12);
	assign ss1 = rotl(a12 + e_q + tj, 5'd7);
	assign ss2 = ss1 ^ a12;
	assign tt1 = ff + d_q + ss2 + (wj ^ wj4);
	assign tt2 = gg + h_q + ss1 + wj;
	assign kidx = bits_q[8:5];
	assign pos  = bits_q[8:3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			cv_q     <= SM3_IV;
			bits_q   <= '0;
			len_q    <= '0;
			rnd_q    <= '0;
			fin_q    <= 1'b0;
			second_q <= 1'b0;
			oidx_q   <= '0;
			for (int i = 0; i < 16; i++) w_q[i] <= '0;
			{a_q, b_q, c_q, d_q, e_q, f_q, g_q, h_q} <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						w_q[kidx] <= {w_q[kidx][23:0],
							(in_item.kind == KIND_FINISH) ? 8'h80 : in_item.message_byte};
						bits_q <= bits_q + 64'd8;
						fin_q  <= (in_item.kind == KIND_FINISH);
						if (in_item.kind == KIND_FINISH) len_q <= bits_q;
						// A marker byte that completes a block compresses it before
						// the length block.
						if (bits_q[8:3] == 6'd63) begin
							{a_q, b_q, c_q, d_q, e_q, f_q, g_q, h_q} <= cv_q;
							rnd_q    <= '0;
							second_q <= (in_item.kind == KIND_FINISH);
							state_q  <= S_COMP;
						end else if (in_item.kind == KIND_FINISH) begin
							state_q <= S_PAD;
						end
					end
				end
				S_PAD: begin
					// Zero-fill after the 0x80 byte; a tail past byte 56 needs an
					// extra compression first.
					for (int k = 0; k < 16; k++) begin
						if (pos != 6'd0 && k == pos[5:2] && pos[1:0] != 2'd0)
							w_q[k] <= w_q[k] << (6'd8 * (6'd4 - {4'd0, pos[1:0]}));
						else if (pos == 6'd0 || k >= pos[5:2])
							w_q[k] <= '0;
					end
					if (pos != 6'd0 && pos > 6'd56) begin
						second_q <= 1'b1;
					end else begin
						second_q <= 1'b0;
						if (pos != 6'd0 || 1'b1) begin
							w_q[14] <= len_q[63:32];
							w_q[15] <= len_q[31:0];
						end
					end
					{a_q, b_q, c_q, d_q, e_q, f_q, g_q, h_q} <= cv_q;
					rnd_q   <= '0;
					state_q <= S_COMP;
				end
				S_COMP: begin
					for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
					w_q[15] <= wn;
					a_q <= tt1; b_q <= a_q; c_q <= rotl(b_q, 5'd9); d_q <= c_q;
					e_q <= perm0(tt2); f_q <= e_q; g_q <= rotl(f_q, 5'd19); h_q <= g_q;
					rnd_q <= rnd_q + 6'd1;
					if (rnd_q == 6'd63) begin
						cv_q <= cv_q ^ {tt1, a_q, rotl(b_q, 5'd9), c_q,
							perm0(tt2), e_q, rotl(f_q, 5'd19), g_q};
						if (!fin_q) begin
							for (int i = 0; i < 16; i++) w_q[i] <= '0;
							state_q <= S_IDLE;
						end else if (second_q) begin
							second_q <= 1'b0;
							for (int i = 0; i < 14; i++) w_q[i] <= '0;
							w_q[14] <= len_q[63:32];
							w_q[15] <= len_q[31:0];
							state_q <= S_PAD;
							bits_q  <= '0;
							fin_q   <= 1'b1;
						end else begin
							oidx_q  <= '0;
							state_q <= S_EMIT;
						end
					end
				end
				S_EMIT: begin
					if (pop) begin
						oidx_q <= oidx_q + 3'd1;
						if (oidx_q == 3'd7) begin
							cv_q    <= SM3_IV;
							bits_q  <= '0;
							fin_q   <= 1'b0;
							for (int i = 0; i < 16; i++) w_q[i] <= '0;
							state_q <= S_IDLE;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

// File: rtl/sm3_hash_engine.sv
`default_nettype none
// Channel  | Handshake       | Payload
// input    | push / full     | in_data  (kind, message_byte)
// result   | empty / pop     | out_data (digest_word, word_index, last)
// A message byte is absorbed by the core in S_IDLE; every 64th byte starts a
// compression, one round per cycle in the round datapath.
// Finish runs a pad step and then a compression, plus a further compression
// when the padding spills into a second block or when the marker byte itself
// completes a block, then eight result words. A four-entry input queue
// absorbs bytes while the core compresses. Reset restores the initial vector.
module sm3_hash_engine (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               push,
	input  sm3_pkg::sm3_in_t  in_data,
	output logic              full,
	output logic              empty,
	input  wire               pop,
	output sm3_pkg::sm3_out_t out_data
);
	import sm3_pkg::*;

	sm3_in_t q_item;
	logic    q_empty, q_take;

	sm3_fifo u_fifo (
		.clk(clk), .arst_n(arst_n), .push(push), .din(in_data), .full(full),
		.pop(q_take), .empty(q_empty), .dout(q_item)
	);

	sm3_core u_core (
		.clk(clk), .arst_n(arst_n), .in_valid(!q_empty), .in_item(q_item),
		.in_take(q_take), .empty(empty), .pop(pop), .result(out_data)
	);

	a_last_idx: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (out_data.last == (out_data.word_index == 3'd7)))
		else $error("last flag mismatch");
	a_no_take_emit: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> !q_take)
		else $error("input taken while emitting");
	a_idx_step: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && pop && out_data.word_index != 3'd7) |=>
		(!empty && out_data.word_index == $past(out_data.word_index) + 3'd1))
		else $error("word index skipped");
endmodule
`default_nettype wire

// File: dv/sm3_checker.sv
`timescale 1ns / 100ps
`default_nettype none
module sm3_checker (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               push,
	input  sm3_pkg::sm3_in_t  in_data,
	input  wire               full,
	input  wire               empty,
	input  wire               pop,
	input  sm3_pkg::sm3_out_t out_data,
	output int                fail_count,
	output int                pending_words
);
	import sm3_pkg::*;

	localparam logic [31:0] IV_WORDS [8] = '{
		32'h7380166F, 32'h4914B2B9, 32'h172442D7, 32'hDA8A0600,
		32'hA96F30BC, 32'h163138AA, 32'hE38DEE4D, 32'hB0FB0E4E
	};
	localparam logic [31:0] TJ_LOW  = 32'h79CC4519;
	localparam logic [31:0] TJ_HIGH = 32'h7A879D8A;

	logic [31:0] chain [8];
	logic [31:0] blk [16];
	logic [63:0] bits_seen;
	sm3_out_t    digest_q [$];

	function automatic logic [31:0] rol(input logic [31:0] x, input int n);
		int m;
		m = n % 32;
		if (m == 0)
			return x;
		return (x << m) | (x >> (32 - m));
	endfunction

	task automatic compress();
		logic [31:0] w [68];
		logic [31:0] a, b, c, d, e, f, g, h, s1, s2, t1, t2, ff, gg, tj;
		for (int j = 0; j < 16; j++)
			w[j] = blk[j];
		for (int j = 16; j < 68; j++) begin
			t1 = w[j-16] ^ w[j-9] ^ rol(w[j-3], 15);
			w[j] = t1 ^ rol(t1, 15) ^ rol(t1, 23) ^ rol(w[j-13], 7) ^ w[j-6];
		end
		{a, b, c, d, e, f, g, h} = {chain[0], chain[1], chain[2], chain[3],
			chain[4], chain[5], chain[6], chain[7]};
		for (int j = 0; j < 64; j++) begin
			if (j < 16) begin
				tj = TJ_LOW;
				ff = a ^ b ^ c;
				gg = e ^ f ^ g;
			end else begin
				tj = TJ_HIGH;
				ff = (a & b) | (a & c) | (b & c);
				gg = (e & f) | (~e & g);
			end
			s1 = rol(rol(a, 12) + e + rol(tj, j), 7);
			s2 = s1 ^ rol(a, 12);
			t1 = ff + d + s2 + (w[j] ^ w[j+4]);
			t2 = gg + h + s1 + w[j];
			d = c;
			c = rol(b, 9);
			b = a;
			a = t1;
			h = g;
			g = rol(f, 19);
			f = e;
			e = t2 ^ rol(t2, 9) ^ rol(t2, 17);
		end
		chain[0] ^= a; chain[1] ^= b; chain[2] ^= c; chain[3] ^= d;
		chain[4] ^= e; chain[5] ^= f; chain[6] ^= g; chain[7] ^= h;
	endtask

	task automatic absorb(input logic [7:0] byte_val);
		int k;
		k = bits_seen[8:5];
		blk[k] = {blk[k][23:0], byte_val};
		bits_seen += 64'd8;
		if (bits_seen[8:0] == 9'd0)
			compress();
	endtask

	task automatic restart();
		for (int i = 0; i < 8; i++)
			chain[i] = IV_WORDS[i];
		for (int i = 0; i < 16; i++)
			blk[i] = '0;
		bits_seen = '0;
	endtask

	task automatic finish_message();
		logic [63:0] msg_len;
		int pos, k, rem;
		sm3_out_t word;
		msg_len = bits_seen;
		absorb(8'h80);
		pos = bits_seen[8:3];
		if (pos != 0) begin
			k = pos / 4;
			rem = pos % 4;
			if (rem != 0) begin
				blk[k] = blk[k] << (8 * (4 - rem));
				k++;
			end
			for (; k < 16; k++)
				blk[k] = '0;
			if (pos * 8 > 448) begin
				compress();
				for (int i = 0; i < 16; i++)
					blk[i] = '0;
			end
		end else begin
			for (int i = 0; i < 16; i++)
				blk[i] = '0;
		end
		blk[14] = msg_len[63:32];
		blk[15] = msg_len[31:0];
		compress();
		for (int i = 0; i < 8; i++) begin
			word.digest_word = chain[i];
			word.word_index = 3'(i);
			word.last = (i == 7);
			digest_q.push_back(word);
		end
		restart();
	endtask

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		$display("sm3_checker: %s got %h expected %h at %0t", what, got, want, $realtime);
		fail_count++;
	endtask

	initial begin
		fail_count = 0;
		restart();
	end

	always @(posedge clk) begin
		sm3_out_t want;
		if (arst_n) begin
			if (pop && !empty) begin
				if (digest_q.size() == 0) begin
					report("unexpected digest word", out_data.digest_word, 32'h0);
				end else begin
					want = digest_q.pop_front();
					if (out_data.digest_word !== want.digest_word)
						report("digest_word", out_data.digest_word, want.digest_word);
					if (out_data.word_index !== want.word_index)
						report("word_index", 32'(out_data.word_index), 32'(want.word_index));
					if (out_data.last !== want.last)
						report("last", 32'(out_data.last), 32'(want.last));
				end
			end
			if (push && !full) begin
				if (in_data.kind == KIND_FINISH)
					finish_message();
				else
					absorb(in_data.message_byte);
			end
		end
		pending_words = digest_q.size();
	end
endmodule
`default_nettype wire

// File: dv/testbench.sv
`timescale 1ns / 100ps
`default_nettype none
module testbench;
	import sm3_pkg::*;

	logic     clk = 1'b0;
	logic     arst_n = 1'b0;
	logic     push = 1'b0;
	logic     pop = 1'b0;
	sm3_in_t  in_data = '0;
	sm3_out_t out_data;
	logic     full, empty;
	int       fail_count, pending_words;
	int       send_idle_pct = 14;
	int       recv_idle_pct = 58;
	bit       hold_recv = 1'b0;
	int       cycle_count = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	sm3_hash_engine dut (
		.clk(clk), .arst_n(arst_n), .push(push), .in_data(in_data), .full(full),
		.empty(empty), .pop(pop), .out_data(out_data)
	);

	sm3_checker checker_i (
		.clk(clk), .arst_n(arst_n), .push(push), .in_data(in_data), .full(full),
		.empty(empty), .pop(pop), .out_data(out_data), .fail_count(fail_count),
		.pending_words(pending_words)
	);

	// Offer one request and hold it until the block takes it. The full flag
	// is sampled mid-cycle, where it holds the value seen at the next edge.
	task automatic send(input logic kind, input logic [7:0] byte_val);
		logic taken;
		while ($urandom_range(99) < send_idle_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		in_data <= '{kind: kind, message_byte: byte_val};
		taken = 1'b0;
		while (!taken) begin
			@(negedge clk);
			taken = !full;
			@(posedge clk);
		end
	endtask

	task automatic send_message(input int len);
		for (int i = 0; i < len; i++)
			send(KIND_BYTE, 8'($urandom));
		send(KIND_FINISH, 8'($urandom));
	endtask

	task automatic drain();
		push <= 1'b0;
		@(posedge clk);
		while (pending_words != 0)
			@(posedge clk);
	endtask

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (!arst_n || hold_recv)
			pop <= 1'b0;
		else
			pop <= ($urandom_range(99) >= recv_idle_pct);
		if (cycle_count > 400000) begin
			$display("testbench: errors");
			$finish;
		end
	end

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty message, "abc", byte extremes, the padding edges.
		send(KIND_FINISH, 8'hFF);
		send(KIND_BYTE, 8'h61); send(KIND_BYTE, 8'h62); send(KIND_BYTE, 8'h63);
		send(KIND_FINISH, 8'h00);
		send(KIND_BYTE, 8'h00); send(KIND_BYTE, 8'hFF);
		send(KIND_BYTE, 8'hAA); send(KIND_BYTE, 8'h55);
		send(KIND_FINISH, 8'h00);
		send_message(55);
		send_message(56);
		send_message(63);

		// The receiver holds off so the block backs up.
		hold_recv = 1'b1;
		fork
			begin
				repeat (3000) @(posedge clk);
				hold_recv = 1'b0;
			end
			begin
				for (int m = 0; m < 6; m++)
					send_message($urandom_range(0, 3));
			end
		join
		drain();

		for (int phase = 0; phase < 3; phase++) begin
			if (phase == 1) begin
				send_idle_pct = 58;
				recv_idle_pct = 14;
			end else if (phase == 2) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			for (int m = 0; m < 4; m++) begin
				if ($urandom_range(9) == 0)
					send(KIND_BYTE, 8'($urandom));
				else
					send_message($urandom_range(0, 4));
			end
			drain();
		end

		repeat (300) @(posedge clk);
		if (fail_count == 0 && pending_words == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end
endmodule
`default_nettype wire

// File: files.f
rtl/sm3_pkg.sv
rtl/sm3_fifo.sv
rtl/sm3_core.sv
rtl/sm3_hash_engine.sv
dv/sm3_checker.sv
dv/testbench.sv
